// File: design/pmrd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Probability map region divider package
// Shared widths, constants, operation codes and the sequencer state type.
// ----------------------------------------------------------------------------
package pmrd_pkg;

	// Field widths.
	localparam int OP_W      = 2;
	localparam int IDX_W     = 16;
	localparam int PROB_W    = 26;
	localparam int SHARE_W   = 25;
	localparam int SUM_W     = 26;
	localparam int REGION_W  = 2;
	localparam int RIN_W     = 3;
	localparam int CFG_IDX_W = 3;

	// Number of target share registers and region slots.
	localparam int TARGET_REGS = 4;

	// Rescale arithmetic: sums of shares, products and divider remainder.
	localparam int ARITH_W = 34;
	localparam int PROD_W  = ARITH_W + SHARE_W;
	localparam int CNT_W   = 5;

	// Parameter defaults.
	localparam int DEF_MAP_CELLS      = 65536;
	localparam int DEF_MAX_REGIONS    = 4;
	localparam int DEF_PROB_FRAC_BITS = 24;

	// Reset values of the configuration registers.
	localparam logic [SHARE_W-1:0] TARGET_RESET  = 25'd4194304;
	localparam logic [RIN_W-1:0]   REGIONS_RESET = 3'd4;
	localparam logic [SHARE_W-1:0] SHARE_MAX     = '1;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_MARK  = 2'd0;
	localparam logic [OP_W-1:0] OP_BEGIN = 2'd1;
	localparam logic [OP_W-1:0] OP_END   = 2'd2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_REGIONS = 3'd4;

	// Sequencer states.
	typedef enum logic [9:0] {
		ST_CLR  = 10'b0000000001,
		ST_IDLE = 10'b0000000010,
		ST_RD   = 10'b0000000100,
		ST_CHK  = 10'b0000001000,
		ST_RSC  = 10'b0000010000,
		ST_MUL  = 10'b0000100000,
		ST_CMP  = 10'b0001000000,
		ST_DIV  = 10'b0010000000,
		ST_FIN  = 10'b0100000000,
		ST_TOT  = 10'b1000000000
	} state_t;

endpackage
`default_nettype wire

// File: design/probability_map_region_divider.sv
// Mark beat: ST_RD, ST_CHK and ST_FIN lie between accept and result. A region
// boundary adds ST_RSC plus, for each later region rescaled, up to 25 shift-add steps
// and 25 divide steps in the shared rescale unit. End beat: one total per cycle while
// out_stall is low. Begin beat and reset: a label clearing sweep over all MAP_CELLS
// cells, during which in_stall is high. Configuration writes are taken every cycle.
`default_nettype none
// ----------------------------------------------------------------------------
// Probability map region divider
// Labels map cells into consecutive regions by cumulative probability and
// reports the probability collected by each region.
// ----------------------------------------------------------------------------
module probability_map_region_divider #(
	parameter int MAP_CELLS      = pmrd_pkg::DEF_MAP_CELLS,
	parameter int MAX_REGIONS    = pmrd_pkg::DEF_MAX_REGIONS,
	parameter int PROB_FRAC_BITS = pmrd_pkg::DEF_PROB_FRAC_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [pmrd_pkg::OP_W-1:0]        op,
	input  wire logic [pmrd_pkg::IDX_W-1:0]       cell_index,
	input  wire logic signed [pmrd_pkg::PROB_W-1:0] cell_prob,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  kind,
	output logic [pmrd_pkg::REGION_W-1:0]         region,
	output logic                                  accepted,
	output logic [pmrd_pkg::SHARE_W-1:0]          actual_share,
	output logic                                  last,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [pmrd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pmrd_pkg::SHARE_W-1:0]     cfg_data
);
	import pmrd_pkg::*;

	localparam int AW = $clog2(MAP_CELLS);
	localparam int LIM = (MAX_REGIONS < TARGET_REGS) ? MAX_REGIONS : TARGET_REGS;
	localparam logic [RIN_W-1:0] REG_LIM = RIN_W'(LIM);
	localparam logic [ARITH_W-1:0] ONE = ARITH_W'(1) << PROB_FRAC_BITS;
	localparam logic [AW-1:0] CLR_LAST = AW'(MAP_CELLS - 1);

	state_t state_q;

	// Label store: one labelled bit per cell.
	logic mem_q [MAP_CELLS];
	logic lbl_rd_q;
	logic [AW-1:0] clr_cnt_q;

	// Configuration registers.
	logic [SHARE_W-1:0] target_q [TARGET_REGS];
	logic [RIN_W-1:0] rin_q;

	// Pass state.
	logic [SHARE_W-1:0] scaled_q [TARGET_REGS];
	logic [SHARE_W-1:0] actual_q [TARGET_REGS];
	logic [SUM_W-1:0] rs_q;
	logic [REGION_W-1:0] cur_q;

	// Current beat.
	logic [IDX_W-1:0] idx_q;
	logic [SHARE_W-1:0] p_q;
	logic blk_q;

	// Rescale unit.
	logic [RIN_W-1:0] k_q;
	logic [ARITH_W-1:0] num_q, den_q;
	logic so_ge_q;
	logic [PROD_W-1:0] acc_q, mcand_q;
	logic [SHARE_W-1:0] mpl_q, quo_q;
	logic [ARITH_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;

	// Pending cell result and output register.
	logic [REGION_W-1:0] res_region_q;
	logic res_acc_q;
	logic out_valid_q, kind_q, acc_out_q, last_q;
	logic [REGION_W-1:0] region_q;
	logic [SHARE_W-1:0] share_q;

	logic [RIN_W-1:0] n;
	logic out_free;
	logic [31:0] idx_ext;
	logic [AW-1:0] addr;
	logic in_range;
	logic [SUM_W:0] sum_w;
	logic [SUM_W-1:0] sum_sat, sum_prev;
	logic [SHARE_W-1:0] prev_sat;
	logic boundary;
	logic [ARITH_W-1:0] so, sa;
	logic [PROD_W-1:0] div_lim;
	logic [ARITH_W-1:0] dstep;
	logic dge;

	// Effective region count.
	always_comb begin
		if (rin_q == '0) begin
			n = RIN_W'(1);
		end else if (rin_q > REG_LIM) begin
			n = REG_LIM;
		end else begin
			n = rin_q;
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign idx_ext = 32'(idx_q);
	assign addr = idx_ext[AW-1:0];
	assign in_range = idx_ext < 32'(MAP_CELLS);

	// Running sum update and region boundary test.
	assign sum_w = {1'b0, rs_q} + (SUM_W + 1)'(p_q);
	assign sum_sat = sum_w[SUM_W] ? '1 : sum_w[SUM_W-1:0];
	assign sum_prev = sum_sat - SUM_W'(p_q);
	assign prev_sat = sum_prev[SUM_W-1] ? SHARE_MAX : sum_prev[SHARE_W-1:0];
	assign boundary = (sum_sat > SUM_W'(scaled_q[cur_q]))
		&& ((RIN_W'(cur_q) + RIN_W'(1)) < n);

	// Target and actual sums over the closed regions.
	always_comb begin
		so = '0;
		sa = '0;
		for (int i = 0; i < TARGET_REGS; i++) begin
			if (i <= int'(cur_q)) begin
				so = so + ARITH_W'(target_q[i]);
				if (i == int'(cur_q)) begin
					sa = sa + ARITH_W'(prev_sat);
				end else begin
					sa = sa + ARITH_W'(actual_q[i]);
				end
			end
		end
	end

	// Divider step and saturation limit.
	assign div_lim = PROD_W'(den_q) << SHARE_W;
	assign dstep = {rem_q[ARITH_W-2:0], quo_q[SHARE_W-1]};
	assign dge = dstep >= den_q;

	// Label store port: clearing sweep or labelling write, registered read.
	always_ff @(posedge clk) begin
		if (state_q == ST_CLR) begin
			mem_q[clr_cnt_q] <= 1'b0;
		end else if (state_q == ST_CHK && !blk_q && in_range && !lbl_rd_q) begin
			mem_q[addr] <= 1'b1;
		end
		lbl_rd_q <= mem_q[addr];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TARGET_REGS; i++) begin
				target_q[i] <= TARGET_RESET;
			end
			rin_q <= REGIONS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index < REG_REGIONS) begin
				target_q[cfg_index[REGION_W-1:0]] <= cfg_data;
			end else if (cfg_index == REG_REGIONS) begin
				rin_q <= cfg_data[RIN_W-1:0];
			end
		end
	end

	// Sequencer and shared rescale unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_cnt_q <= '0;
			for (int i = 0; i < TARGET_REGS; i++) begin
				scaled_q[i] <= '0;
				actual_q[i] <= '0;
			end
			rs_q <= '0;
			cur_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A taken beat empties the output register unless a new one is loaded.
			if (out_valid_q && !out_stall && state_q != ST_FIN && state_q != ST_TOT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						idx_q <= cell_index;
						p_q <= cell_prob[SHARE_W-1:0];
						blk_q <= cell_prob[PROB_W-1];
						unique case (op)
							OP_MARK: begin
								state_q <= ST_RD;
							end
							OP_BEGIN: begin
								for (int i = 0; i < TARGET_REGS; i++) begin
									scaled_q[i] <= target_q[i];
									actual_q[i] <= '0;
								end
								rs_q <= '0;
								cur_q <= '0;
								clr_cnt_q <= '0;
								state_q <= ST_CLR;
							end
							OP_END: begin
								actual_q[cur_q] <= rs_q[SUM_W-1] ? SHARE_MAX
									: rs_q[SHARE_W-1:0];
								k_q <= '0;
								state_q <= ST_TOT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (blk_q || !in_range || lbl_rd_q) begin
						res_region_q <= '0;
						res_acc_q <= 1'b0;
						state_q <= ST_FIN;
					end else if (boundary) begin
						actual_q[cur_q] <= prev_sat;
						so_ge_q <= so >= ONE;
						num_q <= (sa >= ONE) ? '0 : ONE - sa;
						den_q <= ONE - so;
						k_q <= RIN_W'(cur_q) + RIN_W'(1);
						state_q <= ST_RSC;
					end else begin
						rs_q <= sum_sat;
						res_region_q <= cur_q;
						res_acc_q <= 1'b1;
						state_q <= ST_FIN;
					end
				end
				ST_RSC: begin
					if (k_q >= n) begin
						rs_q <= SUM_W'(p_q);
						cur_q <= cur_q + REGION_W'(1);
						res_region_q <= cur_q + REGION_W'(1);
						res_acc_q <= 1'b1;
						state_q <= ST_FIN;
					end else if (so_ge_q) begin
						scaled_q[k_q[REGION_W-1:0]] <= SHARE_MAX;
						k_q <= k_q + RIN_W'(1);
					end else begin
						acc_q <= '0;
						mcand_q <= PROD_W'(num_q);
						mpl_q <= target_q[k_q[REGION_W-1:0]];
						cnt_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// One shift-add step of target times remaining share.
					if (mpl_q[0]) begin
						acc_q <= acc_q + mcand_q;
					end
					mcand_q <= mcand_q << 1;
					mpl_q <= mpl_q >> 1;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(SHARE_W - 1)) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					// A quotient beyond the share width saturates.
					if (acc_q >= div_lim) begin
						scaled_q[k_q[REGION_W-1:0]] <= SHARE_MAX;
						k_q <= k_q + RIN_W'(1);
						state_q <= ST_RSC;
					end else begin
						rem_q <= acc_q[PROD_W-1:SHARE_W];
						quo_q <= acc_q[SHARE_W-1:0];
						cnt_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// One restoring divide step per cycle.
					rem_q <= dge ? dstep - den_q : dstep;
					quo_q <= {quo_q[SHARE_W-2:0], dge};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(SHARE_W - 1)) begin
						scaled_q[k_q[REGION_W-1:0]] <= {quo_q[SHARE_W-2:0], dge};
						k_q <= k_q + RIN_W'(1);
						state_q <= ST_RSC;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q <= 1'b0;
						region_q <= res_region_q;
						acc_out_q <= res_acc_q;
						share_q <= '0;
						last_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						out_valid_q <= 1'b1;
					end
				end
				ST_TOT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q <= 1'b1;
						region_q <= k_q[REGION_W-1:0];
						acc_out_q <= 1'b0;
						share_q <= actual_q[k_q[REGION_W-1:0]];
						last_q <= (k_q + RIN_W'(1)) == n;
						k_q <= k_q + RIN_W'(1);
						if ((k_q + RIN_W'(1)) == n) begin
							state_q <= ST_IDLE;
						end
					end else begin
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign region = region_q;
	assign accepted = acc_out_q;
	assign actual_share = share_q;
	assign last = last_q;

	// While dividing, the divider remainder stays below the divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	// Cell results never carry a share.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !kind) |-> (actual_share == '0))
		else $error("cell result with nonzero share");

	// Region totals follow one another without a gap.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && kind && !last) |=> out_valid)
		else $error("gap inside region total sequence");

endmodule
`default_nettype wire

// File: verif/probability_map_region_divider_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Probability map region divider checker
// Watches the input, output and configuration channels, keeps its own copy
// of the region divider state, and compares every output beat with the
// oldest predicted beat.
// ----------------------------------------------------------------------------
module probability_map_region_divider_chk (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic                                 in_stall,
	input  wire logic [pmrd_pkg::OP_W-1:0]            op,
	input  wire logic [pmrd_pkg::IDX_W-1:0]           cell_index,
	input  wire logic signed [pmrd_pkg::PROB_W-1:0]   cell_prob,
	input  wire logic                                 out_valid,
	input  wire logic                                 out_stall,
	input  wire logic                                 kind,
	input  wire logic [pmrd_pkg::REGION_W-1:0]        region,
	input  wire logic                                 accepted,
	input  wire logic [pmrd_pkg::SHARE_W-1:0]         actual_share,
	input  wire logic                                 last,
	input  wire logic                                 cfg_valid,
	input  wire logic                                 cfg_ready,
	input  wire logic [pmrd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pmrd_pkg::SHARE_W-1:0]         cfg_data,
	output int                                        fail_count,
	output int                                        pending,
	output int                                        checked
);
	import pmrd_pkg::*;

	localparam longint unsigned ONE      = 64'd1 << DEF_PROB_FRAC_BITS;
	localparam longint unsigned SUM_SAT  = (64'd1 << SUM_W) - 1;
	localparam longint unsigned SHARE_SAT = (64'd1 << SHARE_W) - 1;
	localparam logic [2:0]      NO_LABEL = 3'd7;

	typedef struct packed {
		logic                kind;
		logic [REGION_W-1:0] region;
		logic                accepted;
		logic [SHARE_W-1:0]  share;
		logic                last;
	} region_beat_t;

	// Configuration copy.
	longint unsigned share_cfg [TARGET_REGS];
	logic [RIN_W-1:0] regions_cfg;

	// Pass state.
	logic [2:0]      label_mem [DEF_MAP_CELLS];
	longint unsigned prob_sum;
	int              open_region;
	longint unsigned scaled_tgt [TARGET_REGS];
	longint unsigned region_total [TARGET_REGS];

	region_beat_t expected_beats [$];

	function automatic longint unsigned clip_share(longint unsigned v);
		return (v > SHARE_SAT) ? SHARE_SAT : v;
	endfunction

	// Spread the probability still left over the regions after the current one.
	function automatic void retarget_regions(int n);
		longint unsigned so, sa, num;
		so = 0;
		sa = 0;
		for (int k = 0; k <= open_region && k < TARGET_REGS; k++) begin
			so += share_cfg[k];
			sa += region_total[k];
		end
		num = (sa >= ONE) ? 0 : ONE - sa;
		for (int k = open_region + 1; k < n; k++) begin
			if (so >= ONE)
				scaled_tgt[k] = SHARE_SAT;
			else
				scaled_tgt[k] = clip_share((share_cfg[k] * num) / (ONE - so));
		end
	endfunction

	function automatic void push_beat(logic k, int r, logic acc, longint unsigned s, logic l);
		region_beat_t b;
		b.kind     = k;
		b.region   = r[REGION_W-1:0];
		b.accepted = acc;
		b.share    = s[SHARE_W-1:0];
		b.last     = l;
		expected_beats.push_back(b);
	endfunction

	// Work out the output beats caused by one accepted input beat.
	function automatic void divide_beat(logic [OP_W-1:0] code, logic [IDX_W-1:0] idx,
			logic [PROB_W-1:0] raw);
		int n;
		longint unsigned p;
		n = (regions_cfg == 0) ? 1 : (regions_cfg > TARGET_REGS) ? TARGET_REGS : regions_cfg;
		p = raw;
		case (code)
			OP_BEGIN: begin
				foreach (label_mem[i]) label_mem[i] = NO_LABEL;
				prob_sum    = 0;
				open_region = 0;
				for (int k = 0; k < TARGET_REGS; k++) begin
					region_total[k] = 0;
					scaled_tgt[k]   = share_cfg[k];
				end
			end
			OP_END: begin
				region_total[open_region] = clip_share(prob_sum);
				for (int k = 0; k < n; k++)
					push_beat(1'b1, k, 1'b0, region_total[k], k == n - 1);
			end
			OP_MARK: begin
				if (raw[PROB_W-1] || label_mem[idx] != NO_LABEL) begin
					push_beat(1'b0, 0, 1'b0, 0, 1'b1);
				end else begin
					prob_sum = prob_sum + p;
					if (prob_sum > SUM_SAT) prob_sum = SUM_SAT;
					if (prob_sum > scaled_tgt[open_region] && open_region + 1 < n) begin
						region_total[open_region] =
							clip_share((prob_sum >= p) ? prob_sum - p : 0);
						retarget_regions(n);
						prob_sum = p;
						open_region++;
					end
					label_mem[idx] = open_region[2:0];
					push_beat(1'b0, open_region, 1'b1, 0, 1'b1);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	// Sample all three channels at the clock edge; hold the reset state in reset.
	always @(posedge clk) begin
		region_beat_t want;
		if (!arst_n) begin
			for (int k = 0; k < TARGET_REGS; k++) begin
				share_cfg[k]    = TARGET_RESET;
				scaled_tgt[k]   = 0;
				region_total[k] = 0;
			end
			regions_cfg = REGIONS_RESET;
			foreach (label_mem[i]) label_mem[i] = NO_LABEL;
			prob_sum    = 0;
			open_region = 0;
			expected_beats.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < TARGET_REGS)
					share_cfg[cfg_index] = cfg_data;
				else if (cfg_index == REG_REGIONS)
					regions_cfg = cfg_data[RIN_W-1:0];
			end
			if (out_valid && !out_stall) begin
				checked++;
				if (expected_beats.size() == 0) begin
					report_mismatch($sformatf("unexpected beat kind=%0d region=%0d",
						kind, region));
				end else begin
					want = expected_beats.pop_front();
					if (kind !== want.kind || region !== want.region ||
							accepted !== want.accepted || actual_share !== want.share ||
							last !== want.last)
						report_mismatch($sformatf(
							"got k%0d r%0d a%0d s%0d l%0d, want k%0d r%0d a%0d s%0d l%0d",
							kind, region, accepted, actual_share, last, want.kind,
							want.region, want.accepted, want.share, want.last));
				end
			end
			if (in_valid && !in_stall)
				divide_beat(op, cell_index, cell_prob);
			pending = expected_beats.size();
		end
	end

endmodule

// File: verif/probability_map_region_divider_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Probability map region divider testbench
// Runs directed and random division passes through several region and share
// settings, with sender gaps, receiver stalls and a long receiver hold-off.
// ----------------------------------------------------------------------------
module probability_map_region_divider_tb;
	import pmrd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SHARE0 = 3'd0;
	localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
	localparam int                   ONE        = 1 << DEF_PROB_FRAC_BITS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OP_W-1:0] op = OP_MARK;
	logic [IDX_W-1:0] cell_index = '0;
	logic signed [PROB_W-1:0] cell_prob = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic kind;
	logic [REGION_W-1:0] region;
	logic accepted;
	logic [SHARE_W-1:0] actual_share;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SHARE_W-1:0] cfg_data = '0;

	int fail_count, pending, checked;
	int tx_pct = 28, rx_pct = 48;
	int beats_sent = 0, passes = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	logic [IDX_W-1:0] used_cells [$];

	always #1 clk = ~clk;

	probability_map_region_divider u_top (.*);

	probability_map_region_divider_chk u_chk (.*);

	// Run limit.
	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

	// Receiver: random stalls, with one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_pct);
			end
		end
	end

	// Offer one input beat and wait until it is taken.
	task automatic send_beat(logic [OP_W-1:0] code, logic [IDX_W-1:0] idx, int prob);
		if ($urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= code;
		cell_index <= idx;
		cell_prob  <= PROB_W'(prob);
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		beats_sent++;
		if (code == OP_MARK) used_cells.push_back(idx);
		if (code == OP_BEGIN) begin
			used_cells.delete();
			passes++;
		end
	endtask

	// Wait until the block is idle, so that registers may be written.
	task automatic drain_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		do @(negedge clk); while (in_stall);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= SHARE_W'(value);
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	task automatic set_shares(int s0, int s1, int s2, int s3, int n);
		write_reg(REG_SHARE0, s0);
		write_reg(REG_SHARE0 + 3'd1, s1);
		write_reg(REG_SHARE0 + 3'd2, s2);
		write_reg(REG_SHARE0 + 3'd3, s3);
		write_reg(REG_REGIONS, n);
		cfg_valid <= 1'b0;
	endtask

	function automatic int pick_share();
		int r;
		r = $urandom_range(9);
		if (r == 0) return 0;
		if (r == 1) return ONE;
		return $urandom_range(ONE / 8, ONE / 2);
	endfunction

	// Mostly small free cells, some blocked, large or repeated ones.
	task automatic random_mark();
		int r, prob;
		logic [IDX_W-1:0] idx;
		r = $urandom_range(99);
		if (r < 12) prob = -$urandom_range(1, ONE);
		else if (r < 18) prob = $urandom_range(ONE);
		else prob = $urandom_range(1 << 21);
		if ($urandom_range(99) < 15 && used_cells.size() != 0)
			idx = used_cells[$urandom_range(used_cells.size() - 1)];
		else
			idx = IDX_W'($urandom_range(16'hFFFF));
		send_beat(OP_MARK, idx, prob);
	endtask

	task automatic random_pass(int marks);
		send_beat(OP_BEGIN, '0, 0);
		for (int i = 0; i < marks; i++) begin
			if ($urandom_range(49) == 0) send_beat(OP_UNUSED, IDX_W'($urandom), $urandom);
			random_mark();
		end
		send_beat(OP_END, IDX_W'($urandom), $urandom);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass with reset settings: zero, full and blocked cells,
		// a repeated cell, the unused code and a saturating last region.
		send_beat(OP_BEGIN, '0, 0);
		send_beat(OP_MARK, 16'd0, 0);
		send_beat(OP_MARK, 16'hFFFF, ONE);
		send_beat(OP_MARK, 16'hFFFF, 5);
		send_beat(OP_MARK, 16'd1, -ONE);
		send_beat(OP_MARK, 16'd2, -1);
		send_beat(OP_UNUSED, 16'h5A5A, ONE);
		for (int i = 3; i < 9; i++) send_beat(OP_MARK, IDX_W'(i), ONE);
		send_beat(OP_END, '0, 0);

		// Full first share forces the zero divisor; region count above range.
		drain_block();
		set_shares(ONE, 0, ONE, 0, 7);
		send_beat(OP_BEGIN, '0, 0);
		for (int i = 0; i < 5; i++) send_beat(OP_MARK, IDX_W'(100 + i), ONE / 2 + i);
		send_beat(OP_END, '0, 0);

		// A region count of zero acts as a single region.
		drain_block();
		set_shares(0, ONE, 0, ONE, 0);
		send_beat(OP_BEGIN, '0, 0);
		for (int i = 0; i < 4; i++) send_beat(OP_MARK, IDX_W'(200 + i), ONE);
		send_beat(OP_END, '0, 0);

		// Random passes in three phases of sender gap and receiver stall rates.
		for (int p = 0; p < 6; p++) begin
			drain_block();
			if (p < 2) begin
				tx_pct = 28;
				rx_pct = 48;
			end else if (p < 4) begin
				tx_pct = 48;
				rx_pct = 28;
			end else begin
				tx_pct = 0;
				rx_pct = 0;
			end
			set_shares(pick_share(), pick_share(), pick_share(), pick_share(),
				$urandom_range(7));
			if (p == 1) begin
				// Sender pauses mid-pass until every result is back.
				send_beat(OP_BEGIN, '0, 0);
				for (int i = 0; i < 15; i++) random_mark();
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
				for (int i = 0; i < 15; i++) random_mark();
				send_beat(OP_END, '0, 0);
			end else if (p == 2) begin
				// Long receiver hold-off while cells keep coming.
				send_beat(OP_BEGIN, '0, 0);
				hold_req <= 1'b1;
				for (int i = 0; i < 30; i++) random_mark();
				send_beat(OP_END, '0, 0);
			end else begin
				random_pass(20);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Covered %0d input beats over %0d passes, %0d output beats checked,",
			beats_sent, passes, checked);
		$display("with extreme shares and region counts, gaps, stalls and a long hold-off.");
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
